// ===== design/ntc_ar_pkg.sv =====
package ntc_ar_pkg;

    localparam int ADC_W   = 10;
    localparam int RES_W   = 34;
    localparam int TEMP_W  = 16;
    localparam int RREG_W  = 20;
    localparam int COEF_W  = 48;
    localparam int CFG_W   = 48;
    localparam int CADDR_W = 3;
    localparam int SDATA_W = 16;
    localparam int MDATA_W = 56;

    // divider: dividend / divisor / quotient widths
    localparam int DVD_W = 55;
    localparam int DVS_W = 63;

    // register indexes
    localparam logic [CADDR_W-1:0] REG_R_HIGH  = 3'd0;
    localparam logic [CADDR_W-1:0] REG_R_EXTRA = 3'd1;
    localparam logic [CADDR_W-1:0] REG_COEF_0  = 3'd2;
    localparam logic [CADDR_W-1:0] REG_COEF_1  = 3'd3;
    localparam logic [CADDR_W-1:0] REG_COEF_2  = 3'd4;
    localparam logic [CADDR_W-1:0] REG_COEF_3  = 3'd5;

    // ln(2) in Q34
    localparam logic [COEF_W-1:0] LN2_Q34 = 48'd11908177887;

    // datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_PREP1     = 4'd2;
    localparam logic [3:0] OP_PREP2     = 4'd3;
    localparam logic [3:0] OP_DIV_RES   = 4'd4;
    localparam logic [3:0] OP_RES_DONE  = 4'd5;
    localparam logic [3:0] OP_NORM      = 4'd6;
    localparam logic [3:0] OP_LOG       = 4'd7;
    localparam logic [3:0] OP_MUL_GO    = 4'd8;
    localparam logic [3:0] OP_MUL_STORE = 4'd9;
    localparam logic [3:0] OP_DIV_TEMP  = 4'd10;
    localparam logic [3:0] OP_TEMP_DONE = 4'd11;
    localparam logic [3:0] OP_OUT       = 4'd12;

    // multiply schedule
    localparam logic [2:0] MSEL_L1   = 3'd0;
    localparam logic [2:0] MSEL_L2   = 3'd1;
    localparam logic [2:0] MSEL_L3   = 3'd2;
    localparam logic [2:0] MSEL_T1   = 3'd3;
    localparam logic [2:0] MSEL_T2   = 3'd4;
    localparam logic [2:0] MSEL_T3   = 3'd5;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] mul_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mul_done;
    } dp_status_t;

endpackage

// ===== design/ntc_ar_div.sv =====
module ntc_ar_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ntc_ar_pkg::DVD_W-1:0]   dividend,
    input  logic [ntc_ar_pkg::DVS_W-1:0]   divisor,
    output logic                           done,
    output logic [ntc_ar_pkg::DVD_W-1:0]   quotient
);

    localparam int DVD_W = ntc_ar_pkg::DVD_W;
    localparam int DVS_W = ntc_ar_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            q_next    = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            q_next   = {q_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/ntc_ar_mul.sv =====
module ntc_ar_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [ntc_ar_pkg::COEF_W-1:0] op_a,
    input  logic signed [ntc_ar_pkg::COEF_W-1:0] op_b,
    output logic                               done,
    output logic signed [63:0]                 result
);

    localparam int W = ntc_ar_pkg::COEF_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [W-1:0]  ma_reg, ma_next;
    logic [W-1:0]  mb_reg, mb_next;
    logic          neg_reg, neg_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [W+15:0] pp;
    logic [2*W-1:0] pp_ext;
    logic [63:0]   mag_res;

    // a*b/2^32 truncated toward zero, 16 bits of b per cycle
    always_comb begin
        pp        = ma_reg * mb_reg[15:0];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        case (cnt_reg)
            2'd0:    pp_ext = {32'd0, pp};
            2'd1:    pp_ext = {16'd0, pp, 16'd0};
            default: pp_ext = {pp, 32'd0};
        endcase
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ma_next   = op_a[W-1] ? W'(-op_a) : W'(op_a);
            mb_next   = op_b[W-1] ? W'(-op_b) : W'(op_b);
            neg_next  = op_a[W-1] ^ op_b[W-1];
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + pp_ext;
            mb_next  = {16'd0, mb_reg[W-1:16]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
    end

    assign mag_res = {1'b0, acc_reg[94:32]};
    assign result  = neg_reg ? -$signed(mag_res) : $signed(mag_res);
    assign done    = done_reg;

endmodule

// ===== design/ntc_ar_ctrl.sv =====
module ntc_ar_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output ntc_ar_pkg::dp_cmd_t    cmd,
    input  ntc_ar_pkg::dp_status_t status
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP1 = 4'd1;
    localparam logic [3:0] ST_PREP2 = 4'd2;
    localparam logic [3:0] ST_DIVR  = 4'd3;
    localparam logic [3:0] ST_DIVRW = 4'd4;
    localparam logic [3:0] ST_NORM  = 4'd5;
    localparam logic [3:0] ST_LOG   = 4'd6;
    localparam logic [3:0] ST_MULGO = 4'd7;
    localparam logic [3:0] ST_MULW  = 4'd8;
    localparam logic [3:0] ST_DIVT  = 4'd9;
    localparam logic [3:0] ST_DIVTW = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam logic [4:0] LOG_LAST = 5'd29;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] sel_reg, sel_next;
    logic       ovalid_reg, ovalid_next;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        ovalid_next = ovalid_reg;
        cmd.op      = ntc_ar_pkg::OP_NONE;
        cmd.mul_sel = sel_reg;
        s_tready    = 1'b0;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = ntc_ar_pkg::OP_LOAD;
                    state_next = ST_PREP1;
                end
            end
            ST_PREP1: begin
                cmd.op     = ntc_ar_pkg::OP_PREP1;
                state_next = ST_PREP2;
            end
            ST_PREP2: begin
                cmd.op     = ntc_ar_pkg::OP_PREP2;
                state_next = ST_DIVR;
            end
            ST_DIVR: begin
                cmd.op     = ntc_ar_pkg::OP_DIV_RES;
                state_next = ST_DIVRW;
            end
            ST_DIVRW: begin
                if (status.div_done) begin
                    cmd.op     = ntc_ar_pkg::OP_RES_DONE;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                cmd.op     = ntc_ar_pkg::OP_NORM;
                cnt_next   = '0;
                state_next = ST_LOG;
            end
            ST_LOG: begin
                cmd.op   = ntc_ar_pkg::OP_LOG;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LOG_LAST) begin
                    sel_next   = ntc_ar_pkg::MSEL_L1;
                    state_next = ST_MULGO;
                end
            end
            ST_MULGO: begin
                cmd.op     = ntc_ar_pkg::OP_MUL_GO;
                state_next = ST_MULW;
            end
            ST_MULW: begin
                if (status.mul_done) begin
                    cmd.op   = ntc_ar_pkg::OP_MUL_STORE;
                    sel_next = sel_reg + 1'b1;
                    if (sel_reg == ntc_ar_pkg::MSEL_T3)
                        state_next = ST_DIVT;
                    else
                        state_next = ST_MULGO;
                end
            end
            ST_DIVT: begin
                cmd.op     = ntc_ar_pkg::OP_DIV_TEMP;
                state_next = ST_DIVTW;
            end
            ST_DIVTW: begin
                if (status.div_done) begin
                    cmd.op     = ntc_ar_pkg::OP_TEMP_DONE;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    cmd.op      = ntc_ar_pkg::OP_OUT;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            sel_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign m_tvalid = ovalid_reg;

endmodule

// ===== design/ntc_ar_dp.sv =====
module ntc_ar_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ntc_ar_pkg::ADC_W-1:0]        adc_reading,
    input  logic                                cfg_wr_en,
    input  logic [ntc_ar_pkg::CADDR_W-1:0]      cfg_addr,
    input  logic [ntc_ar_pkg::CFG_W-1:0]        cfg_wdata,
    input  ntc_ar_pkg::dp_cmd_t                 cmd,
    output ntc_ar_pkg::dp_status_t              status,
    output logic [ntc_ar_pkg::RES_W-1:0]        resistance_q4,
    output logic [ntc_ar_pkg::TEMP_W-1:0]       temperature_q6,
    output logic                                low_range_on
);

    localparam int W  = ntc_ar_pkg::COEF_W;
    localparam int RW = ntc_ar_pkg::RREG_W;

    // configuration
    logic [RW-1:0]       r_high_reg, r_extra_reg;
    logic signed [W-1:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic                low_range_reg;

    // working registers
    logic [9:0]          a_reg;
    logic [9:0]          diff_reg;
    logic [39:0]         rr_reg;
    logic [20:0]         sum_reg;
    logic [49:0]         num_reg;
    logic [30:0]         den_reg;
    logic [50:0]         rhden_reg, reden_reg;
    logic [34:0]         rq4_reg;
    logic [30:0]         m_reg;
    logic [5:0]          k_reg;
    logic [29:0]         frac_reg;
    logic signed [63:0]  l1_reg, l2_reg, l3_reg, poly_reg;
    logic [33:0]         res_reg;
    logic [15:0]         temp_reg;
    logic [33:0]         res_out_reg;
    logic [15:0]         temp_out_reg;
    logic                low_out_reg;

    // unit connections
    logic                div_start, div_done;
    logic [54:0]         div_dvd, div_q;
    logic [62:0]         div_dvs;
    logic                mul_start, mul_done;
    logic signed [W-1:0] mul_a, mul_b;
    logic signed [63:0]  mul_res;

    logic [34:0]         x;
    logic [5:0]          lead;
    logic [64:0]         norm_shift;
    logic [61:0]         sq;
    logic [53:0]         num10, reden5;
    logic                go_low, go_high;
    logic signed [36:0]  lg;
    logic                poly_pos;

    always_comb begin
        x    = (div_q[34:0] == '0) ? 35'd1 : div_q[34:0];
        lead = '0;
        for (int i = 0; i < 35; i++) begin
            if (rq4_reg[i])
                lead = 6'(i);
        end
        norm_shift = {rq4_reg, 30'd0} >> lead;
        sq         = m_reg * m_reg;
        num10      = {num_reg, 3'd0} + {3'd0, num_reg, 1'b0};
        reden5     = {1'b0, reden_reg, 2'd0} + {3'd0, reden_reg};
        go_low     = num10 < {3'd0, rhden_reg};
        go_high    = {4'd0, num_reg} > reden5;
        lg         = $signed({1'b0, k_reg, frac_reg}) - $signed(37'd4 << 30);
        poly_pos   = !poly_reg[63] && (poly_reg != '0);
    end

    assign div_start = (cmd.op == ntc_ar_pkg::OP_DIV_RES) ||
                       (cmd.op == ntc_ar_pkg::OP_DIV_TEMP);
    assign div_dvd   = (cmd.op == ntc_ar_pkg::OP_DIV_RES) ? {1'b0, num_reg, 4'd0}
                                                          : (55'd1 << 54);
    assign div_dvs   = (cmd.op == ntc_ar_pkg::OP_DIV_RES) ? {32'd0, den_reg}
                     : (poly_pos ? poly_reg[62:0] : 63'd1);

    assign mul_start = (cmd.op == ntc_ar_pkg::OP_MUL_GO);
    always_comb begin
        case (cmd.mul_sel)
            ntc_ar_pkg::MSEL_L1: begin
                mul_a = W'(lg);
                mul_b = ntc_ar_pkg::LN2_Q34;
            end
            ntc_ar_pkg::MSEL_L2: begin
                mul_a = l1_reg[W-1:0];
                mul_b = l1_reg[W-1:0];
            end
            ntc_ar_pkg::MSEL_L3: begin
                mul_a = l2_reg[W-1:0];
                mul_b = l1_reg[W-1:0];
            end
            ntc_ar_pkg::MSEL_T1: begin
                mul_a = c1_reg;
                mul_b = l1_reg[W-1:0];
            end
            ntc_ar_pkg::MSEL_T2: begin
                mul_a = c2_reg;
                mul_b = l2_reg[W-1:0];
            end
            default: begin
                mul_a = c3_reg;
                mul_b = l3_reg[W-1:0];
            end
        endcase
    end

    ntc_ar_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    ntc_ar_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign status.div_done = div_done;
    assign status.mul_done = mul_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_high_reg    <= RW'(4700);
            r_extra_reg   <= RW'(470);
            c0_reg        <= '0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            c3_reg        <= '0;
            low_range_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    ntc_ar_pkg::REG_R_HIGH:  r_high_reg  <= cfg_wdata[RW-1:0];
                    ntc_ar_pkg::REG_R_EXTRA: r_extra_reg <= cfg_wdata[RW-1:0];
                    ntc_ar_pkg::REG_COEF_0:  c0_reg      <= cfg_wdata;
                    ntc_ar_pkg::REG_COEF_1:  c1_reg      <= cfg_wdata;
                    ntc_ar_pkg::REG_COEF_2:  c2_reg      <= cfg_wdata;
                    ntc_ar_pkg::REG_COEF_3:  c3_reg      <= cfg_wdata;
                    default: ;
                endcase
            end
            // both thresholds met: back to high wins
            if (cmd.op == ntc_ar_pkg::OP_RES_DONE) begin
                if (go_high)
                    low_range_reg <= 1'b0;
                else if (go_low)
                    low_range_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            ntc_ar_pkg::OP_LOAD: begin
                a_reg <= (adc_reading == '0) ? 10'd1 : adc_reading;
            end
            ntc_ar_pkg::OP_PREP1: begin
                diff_reg <= 10'(11'd1024 - {1'b0, a_reg});
                rr_reg   <= r_high_reg * r_extra_reg;
                sum_reg  <= {1'b0, r_high_reg} + {1'b0, r_extra_reg};
            end
            ntc_ar_pkg::OP_PREP2: begin
                if (!low_range_reg) begin
                    num_reg <= 50'(r_high_reg * diff_reg);
                    den_reg <= {21'd0, a_reg};
                end else begin
                    num_reg <= rr_reg * diff_reg;
                    den_reg <= (sum_reg == '0) ? 31'd1 : sum_reg * a_reg;
                end
            end
            ntc_ar_pkg::OP_DIV_RES: begin
                rhden_reg <= r_high_reg * den_reg;
                reden_reg <= r_extra_reg * den_reg;
            end
            ntc_ar_pkg::OP_RES_DONE: begin
                rq4_reg <= x;
                if (div_q[54:34] != '0)
                    res_reg <= '1;
                else
                    res_reg <= div_q[33:0];
            end
            ntc_ar_pkg::OP_NORM: begin
                k_reg    <= lead;
                m_reg    <= norm_shift[30:0];
                frac_reg <= '0;
                poly_reg <= 64'(c0_reg);
            end
            ntc_ar_pkg::OP_LOG: begin
                // square the mantissa; a carry past 2.0 yields a fraction bit
                m_reg    <= sq[61] ? sq[61:31] : sq[60:30];
                frac_reg <= {frac_reg[28:0], sq[61]};
            end
            ntc_ar_pkg::OP_MUL_STORE: begin
                case (cmd.mul_sel)
                    ntc_ar_pkg::MSEL_L1: l1_reg <= mul_res;
                    ntc_ar_pkg::MSEL_L2: l2_reg <= mul_res;
                    ntc_ar_pkg::MSEL_L3: l3_reg <= mul_res;
                    default:             poly_reg <= poly_reg + mul_res;
                endcase
            end
            ntc_ar_pkg::OP_TEMP_DONE: begin
                if (!poly_pos || div_q[54:16] != '0)
                    temp_reg <= '1;
                else
                    temp_reg <= div_q[15:0];
            end
            ntc_ar_pkg::OP_OUT: begin
                res_out_reg  <= res_reg;
                temp_out_reg <= temp_reg;
                low_out_reg  <= low_range_reg;
            end
            default: ;
        endcase
    end

    assign resistance_q4  = res_out_reg;
    assign temperature_q6 = temp_out_reg;
    assign low_range_on   = low_out_reg;

endmodule

// ===== design/ntc_autorange_temperature_core.sv =====
// Thermistor temperature from a 10-bit divider sample. Each transaction on the
// s_ side carries one ADC reading; one transaction on the m_ side returns the
// resistance (1/16 ohm), the temperature (kelvin * 64) and the range select to
// drive for the next sample. Each item runs two 55-step restoring divisions
// (resistance and the final reciprocal) in one shared divider, 30 squaring
// steps of the log2 unit, and six 48-bit products, each accumulated from
// 16-bit slices of one operand in a 48x16 multiplier. One item is in flight
// at a time; a new item is accepted while the previous result waits on m_,
// and it stalls before output until that result is taken. Registers must be
// written through cfg_wr_en/cfg_addr/cfg_wdata only while idle; the block
// does not enforce it.
module ntc_autorange_temperature_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ntc_ar_pkg::SDATA_W-1:0]      s_tdata,  // [9:0] adc_reading
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [33:0] resistance_q4, [49:34] temperature_q6, [50] low_range_on
    output logic [ntc_ar_pkg::MDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ntc_ar_pkg::CADDR_W-1:0]      cfg_addr,
    input  logic [ntc_ar_pkg::CFG_W-1:0]        cfg_wdata
);

    ntc_ar_pkg::dp_cmd_t    cmd;
    ntc_ar_pkg::dp_status_t status;
    logic [ntc_ar_pkg::RES_W-1:0]  resistance_q4;
    logic [ntc_ar_pkg::TEMP_W-1:0] temperature_q6;
    logic                          low_range_on;

    ntc_ar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ntc_ar_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .adc_reading    (s_tdata[ntc_ar_pkg::ADC_W-1:0]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .status         (status),
        .resistance_q4  (resistance_q4),
        .temperature_q6 (temperature_q6),
        .low_range_on   (low_range_on)
    );

    assign m_tdata = {5'd0, low_range_on, temperature_q6, resistance_q4};

endmodule
